>>> src/tcw_pkg.sv
// Package for the text console writer: cell widths, field widths and fixed codes.
// Used by tcw_screen_ram and text_console_writer_unit; depends on nothing.
`default_nettype none

package tcw_pkg;

  // Field widths of the request and result ports.
  localparam int unsigned CELL_W  = 16;
  localparam int unsigned GLYPH_W = 8;
  localparam int unsigned ATTR_W  = 8;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned COL_W   = 7;

  // Blank cell: space in light grey on black.
  localparam logic [CELL_W-1:0]  BLANK_CELL     = 16'h0720;
  // Glyph code that moves the cursor to the next row instead of printing.
  localparam logic [GLYPH_W-1:0] NEWLINE_GLYPH  = 8'd10;
  // Attribute after reset: light grey on black.
  localparam logic [ATTR_W-1:0]  RESET_ATTR     = 8'h07;

  // Request operation codes.
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

endpackage

`default_nettype wire

>>> src/tcw_screen_ram.sv
// Screen store of the text console: one write port, one read port, registered read data.
// Depends on tcw_pkg for the cell width.
`default_nettype none

module tcw_screen_ram #(
  parameter int unsigned Depth = 2000,
  parameter int unsigned AddrW = 11
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [AddrW-1:0]              waddr_i,
  input  wire logic [tcw_pkg::CELL_W-1:0]    wdata_i,
  input  wire logic [AddrW-1:0]              raddr_i,
  output logic      [tcw_pkg::CELL_W-1:0]    rdata_o
);

  logic [tcw_pkg::CELL_W-1:0] mem_q [Depth];
  logic [tcw_pkg::CELL_W-1:0] rdata_q;

  // Synchronous write and registered read; a read of the address written in the same
  // cycle returns the old cell.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/text_console_writer_unit.sv
// Text console writer: cursor, attribute register, sequencer for puts, reads and scrolls.
// Depends on tcw_pkg and tcw_screen_ram.
//
//   Channel   Direction  Handshake                  Payload
//   request   in         start high, busy low       operation_i, character_i,
//                                                   read_row_i, read_column_i
//   result    out        done_o, one cycle          cell_word_o, cursor_row_o,
//                                                   cursor_column_o, scrolled_o
//   config    in         text_attribute_we_i        text_attribute_i
//
// A put without scroll passes through S_PUT, a read through S_RDADR and S_RDOUT, before
// the registered result is shown. A put that scrolls also passes through S_COPY, S_TAIL
// and S_BLANK: one pass over the store through the single memory write port copies each
// row up and then blanks the bottom row.
// After reset the block clears every cell of the store with busy high.
// The result is registered and stays one cycle; busy falls in the cycle the result is
// shown, so the next request can be taken then. The receiver cannot stall.
`default_nettype none

module text_console_writer_unit #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          operation_i,
  input  wire logic [tcw_pkg::GLYPH_W-1:0]   character_i,
  input  wire logic [tcw_pkg::ROW_W-1:0]     read_row_i,
  input  wire logic [tcw_pkg::COL_W-1:0]     read_column_i,
  input  wire logic                          text_attribute_we_i,
  input  wire logic [tcw_pkg::ATTR_W-1:0]    text_attribute_i,
  output logic                               done_o,
  output logic      [tcw_pkg::CELL_W-1:0]    cell_word_o,
  output logic      [tcw_pkg::ROW_W-1:0]     cursor_row_o,
  output logic      [tcw_pkg::COL_W-1:0]     cursor_column_o,
  output logic                               scrolled_o
);

  localparam int unsigned Cells = ROWS * COLUMNS;
  localparam int unsigned CellW = $clog2(Cells);
  localparam int unsigned RowW  = $clog2(ROWS);
  localparam int unsigned ColW  = $clog2(COLUMNS);

  localparam logic [CellW-1:0] LastCopy   = CellW'((ROWS - 1) * COLUMNS - 1);
  localparam logic [CellW-1:0] FirstBlank = CellW'((ROWS - 1) * COLUMNS);
  localparam logic [CellW-1:0] LastCell   = CellW'(Cells - 1);
  localparam logic [CellW-1:0] RowStride  = CellW'(COLUMNS);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RDADR = 3'd2;
  localparam logic [2:0] S_RDOUT = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;
  localparam logic [2:0] S_COPY  = 3'd5;
  localparam logic [2:0] S_TAIL  = 3'd6;
  localparam logic [2:0] S_BLANK = 3'd7;

  logic [2:0]                     state_q, state_d;
  logic [CellW-1:0]               ptr_q, ptr_d;
  logic [RowW-1:0]                row_q, row_d;
  logic [ColW-1:0]                col_q, col_d;
  logic [tcw_pkg::ATTR_W-1:0]     attr_q, attr_d;
  logic                           done_q, done_d;
  logic [tcw_pkg::CELL_W-1:0]     cell_q, cell_d;
  logic                           scr_q, scr_d;

  logic                           op_q;
  logic [tcw_pkg::GLYPH_W-1:0]    ch_q;
  logic [tcw_pkg::ROW_W-1:0]      rr_q;
  logic [tcw_pkg::COL_W-1:0]      rc_q;

  logic                           ram_we;
  logic [CellW-1:0]               ram_waddr;
  logic [tcw_pkg::CELL_W-1:0]     ram_wdata;
  logic [CellW-1:0]               ram_raddr;
  logic [tcw_pkg::CELL_W-1:0]     ram_rdata;

  logic                           accept;
  logic [CellW-1:0]               put_addr;
  logic [CellW-1:0]               read_addr;
  logic                           read_in_range;
  logic                           last_row;
  logic                           last_col;
  logic [31:0]                    row_ext;
  logic [31:0]                    col_ext;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  // Linear cell addresses for the cursor and for the requested read cell.
  assign put_addr      = CellW'(32'(row_q) * COLUMNS + 32'(col_q));
  assign read_addr     = CellW'(32'(rr_q) * COLUMNS + 32'(rc_q));
  assign read_in_range = (32'(rr_q) < ROWS) && (32'(rc_q) < COLUMNS);
  assign last_row      = (32'(row_q) == ROWS - 1);
  assign last_col      = (32'(col_q) == COLUMNS - 1);

  tcw_screen_ram #(
    .Depth (Cells),
    .AddrW (CellW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer: clear pass, read, put, and the row-by-row scroll pass.
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    row_d     = row_q;
    col_d     = col_q;
    done_d    = 1'b0;
    cell_d    = cell_q;
    scr_d     = scr_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = tcw_pkg::BLANK_CELL;
    ram_raddr = read_addr;
    attr_d    = text_attribute_we_i ? text_attribute_i : attr_q;

    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (ptr_q == LastCell) begin
          ptr_d   = '0;
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q + CellW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          state_d = (operation_i == tcw_pkg::OP_READ) ? S_RDADR : S_PUT;
        end
      end
      S_RDADR: begin
        state_d = S_RDOUT;
      end
      S_RDOUT: begin
        done_d  = 1'b1;
        cell_d  = read_in_range ? ram_rdata : '0;
        scr_d   = 1'b0;
        state_d = S_IDLE;
      end
      S_PUT: begin
        cell_d = '0;
        scr_d  = 1'b0;
        if (ch_q != tcw_pkg::NEWLINE_GLYPH) begin
          ram_we    = 1'b1;
          ram_waddr = put_addr;
          ram_wdata = {attr_q, ch_q};
        end
        if ((ch_q == tcw_pkg::NEWLINE_GLYPH) || last_col) begin
          // Move to the next row, scrolling when already on the bottom row.
          col_d = '0;
          if (last_row) begin
            scr_d   = 1'b1;
            ptr_d   = '0;
            state_d = S_COPY;
          end else begin
            row_d   = row_q + RowW'(1);
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          col_d   = col_q + ColW'(1);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_COPY: begin
        // Read the cell one row below; write the one read in the previous cycle.
        ram_raddr = ptr_q + RowStride;
        if (ptr_q != '0) begin
          ram_we    = 1'b1;
          ram_waddr = ptr_q - CellW'(1);
          ram_wdata = ram_rdata;
        end
        if (ptr_q == LastCopy) begin
          state_d = S_TAIL;
        end else begin
          ptr_d = ptr_q + CellW'(1);
        end
      end
      S_TAIL: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        ptr_d     = FirstBlank;
        state_d   = S_BLANK;
      end
      S_BLANK: begin
        ram_we = 1'b1;
        if (ptr_q == LastCell) begin
          ptr_d   = '0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          ptr_d = ptr_q + CellW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state, cursor and attribute.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ptr_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
      attr_q  <= tcw_pkg::RESET_ATTR;
      done_q  <= 1'b0;
      scr_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      row_q   <= row_d;
      col_q   <= col_d;
      attr_q  <= attr_d;
      done_q  <= done_d;
      scr_q   <= scr_d;
    end
  end

  // Request fields and result cell are payload and need no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= operation_i;
      ch_q <= character_i;
      rr_q <= read_row_i;
      rc_q <= read_column_i;
    end
    cell_q <= cell_d;
  end

  // Result ports.
  assign row_ext         = 32'(row_q);
  assign col_ext         = 32'(col_q);
  assign done_o          = done_q;
  assign cell_word_o     = cell_q;
  assign cursor_row_o    = row_ext[tcw_pkg::ROW_W-1:0];
  assign cursor_column_o = col_ext[tcw_pkg::COL_W-1:0];
  assign scrolled_o      = scr_q;

  // A result is shown only once the sequencer is back in idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == S_IDLE))
    else $error("result strobe outside idle");

  // A scroll always leaves the cursor at column 0 of the bottom row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && scrolled_o) |-> (last_row && (col_q == '0)))
    else $error("scroll left cursor off bottom row start");

  // An accepted request makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("request accepted without going busy");

  // The cursor column and row stay on the screen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(col_q) < COLUMNS) && (32'(row_q) < ROWS))
    else $error("cursor outside screen");

  // Every put request ends with a strobe carrying a zero cell word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (op_q == tcw_pkg::OP_PUT)) |-> (cell_word_o == '0))
    else $error("put result carries a cell word");

endmodule

`default_nettype wire

>>> bench/text_console_writer_unit_tb.sv
// Self-checking bench for text_console_writer_unit: puts, newlines, scrolls and cell reads.
// A clocked driver sends requests from a queue and a clocked monitor checks each result
// against a screen model kept here. Depends on tcw_pkg and the unit itself.
`default_nettype none

module text_console_writer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COLUMNS       = 80;
  localparam int unsigned ROWS          = 25;
  localparam int unsigned SCREEN_CELLS  = COLUMNS * ROWS;
  localparam int unsigned PHASE_COUNT   = 5;
  localparam int unsigned PHASE_ITEMS   = 320;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES   = 8;

  typedef enum logic [1:0] {ENTRY_REQUEST, ENTRY_CONFIG, ENTRY_DRAIN} entry_kind_e;

  typedef struct packed {
    logic                        operation;
    logic [tcw_pkg::GLYPH_W-1:0] glyph;
    logic [tcw_pkg::ROW_W-1:0]   row;
    logic [tcw_pkg::COL_W-1:0]   column;
  } request_t;

  typedef struct packed {
    logic [tcw_pkg::CELL_W-1:0] cell_word;
    logic [tcw_pkg::ROW_W-1:0]  cursor_row;
    logic [tcw_pkg::COL_W-1:0]  cursor_column;
    logic                       scrolled;
  } console_reply_t;

  typedef struct {
    entry_kind_e                kind;
    request_t                   req;
    logic [tcw_pkg::ATTR_W-1:0] attr;
    int unsigned                gap;
  } pending_t;

  // Clock, reset and block inputs, all known from time zero.
  logic                         clk_i               = 1'b0;
  logic                         rst_ni              = 1'b0;
  logic                         start               = 1'b0;
  logic                         operation_i         = tcw_pkg::OP_PUT;
  logic [tcw_pkg::GLYPH_W-1:0]  character_i         = '0;
  logic [tcw_pkg::ROW_W-1:0]    read_row_i          = '0;
  logic [tcw_pkg::COL_W-1:0]    read_column_i       = '0;
  logic                         text_attribute_we_i = 1'b0;
  logic [tcw_pkg::ATTR_W-1:0]   text_attribute_i    = tcw_pkg::RESET_ATTR;

  logic                         busy;
  logic                         done_o;
  logic [tcw_pkg::CELL_W-1:0]   cell_word_o;
  logic [tcw_pkg::ROW_W-1:0]    cursor_row_o;
  logic [tcw_pkg::COL_W-1:0]    cursor_column_o;
  logic                         scrolled_o;

  text_console_writer_unit #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .operation_i        (operation_i),
    .character_i        (character_i),
    .read_row_i         (read_row_i),
    .read_column_i      (read_column_i),
    .text_attribute_we_i(text_attribute_we_i),
    .text_attribute_i   (text_attribute_i),
    .done_o             (done_o),
    .cell_word_o        (cell_word_o),
    .cursor_row_o       (cursor_row_o),
    .cursor_column_o    (cursor_column_o),
    .scrolled_o         (scrolled_o)
  );

  // Screen model and cursor as the block should hold them.
  logic [tcw_pkg::CELL_W-1:0] screen_model [SCREEN_CELLS];
  int unsigned                cursor_row_model = 0;
  int unsigned                cursor_col_model = 0;
  logic [tcw_pkg::ATTR_W-1:0] attr_model       = tcw_pkg::RESET_ATTR;

  pending_t          pending_q [$];
  console_reply_t    console_replies_q [$];
  request_t          in_flight;
  pending_t          head;
  logic              start_next;
  logic              we_next;
  int unsigned       gap_left      = 0;
  int unsigned       quiet_cycles  = 0;
  int unsigned       requests_sent = 0;
  int unsigned       replies_seen  = 0;
  int unsigned       mismatch_count = 0;
  logic              idle_on       = 1'b0;

  // Bookkeeping used to size the run limit.
  longint unsigned   request_total = 0;
  longint unsigned   put_total     = 0;
  longint unsigned   newline_total = 0;
  longint unsigned   config_total  = 0;
  longint unsigned   cycle_count   = 0;
  longint unsigned   cycle_limit   = '1;

  // Moves the model cursor to the next row and scrolls when it runs off the bottom.
  function automatic logic advance_row();
    cursor_col_model = 0;
    if (cursor_row_model + 1 >= ROWS) begin
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
        screen_model[i] = screen_model[i + COLUMNS];
      end
      for (int i = (ROWS - 1) * COLUMNS; i < SCREEN_CELLS; i++) begin
        screen_model[i] = tcw_pkg::BLANK_CELL;
      end
      cursor_row_model = ROWS - 1;
      return 1'b1;
    end
    cursor_row_model++;
    return 1'b0;
  endfunction

  // Applies one request to the model and returns the reply it should produce.
  function automatic console_reply_t apply_console_request(request_t req);
    console_reply_t reply;
    reply = '0;
    if (req.operation == tcw_pkg::OP_READ) begin
      if (req.row < ROWS && req.column < COLUMNS) begin
        reply.cell_word = screen_model[req.row * COLUMNS + req.column];
      end
    end else if (req.glyph == tcw_pkg::NEWLINE_GLYPH) begin
      reply.scrolled = advance_row();
    end else begin
      screen_model[cursor_row_model * COLUMNS + cursor_col_model] = {attr_model, req.glyph};
      cursor_col_model++;
      if (cursor_col_model >= COLUMNS) begin
        reply.scrolled = advance_row();
      end
    end
    reply.cursor_row    = cursor_row_model[tcw_pkg::ROW_W-1:0];
    reply.cursor_column = cursor_col_model[tcw_pkg::COL_W-1:0];
    return reply;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic queue_request(input logic op, input logic [tcw_pkg::GLYPH_W-1:0] g,
                               input logic [tcw_pkg::ROW_W-1:0] r,
                               input logic [tcw_pkg::COL_W-1:0] c);
    pending_t p;
    p.kind = ENTRY_REQUEST;
    p.req  = '{operation: op, glyph: g, row: r, column: c};
    p.attr = '0;
    p.gap  = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
    pending_q.push_back(p);
    request_total++;
    if (op == tcw_pkg::OP_PUT) begin
      put_total++;
      if (g == tcw_pkg::NEWLINE_GLYPH) newline_total++;
    end
  endtask

  // A put carries random read fields, which the block must ignore.
  task automatic queue_put(input logic [tcw_pkg::GLYPH_W-1:0] g);
    queue_request(tcw_pkg::OP_PUT, g, tcw_pkg::ROW_W'($urandom), tcw_pkg::COL_W'($urandom));
  endtask

  // A read carries a random glyph, which the block must ignore.
  task automatic queue_read(input int unsigned r, input int unsigned c);
    queue_request(tcw_pkg::OP_READ, tcw_pkg::GLYPH_W'($urandom), tcw_pkg::ROW_W'(r),
                  tcw_pkg::COL_W'(c));
  endtask

  task automatic queue_hold(input entry_kind_e kind, input logic [tcw_pkg::ATTR_W-1:0] a);
    pending_t p;
    p.kind = kind;
    p.req  = '0;
    p.attr = a;
    p.gap  = 0;
    pending_q.push_back(p);
    if (kind == ENTRY_CONFIG) config_total++;
  endtask

  // Clock.
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Driver: sends requests in queue order and writes the attribute only while idle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      start_next = start;
      we_next    = 1'b0;
      if (start && !busy) begin
        console_replies_q.push_back(apply_console_request(in_flight));
        requests_sent = requests_sent + 1;
        start_next = 1'b0;
      end
      if (!start && !busy && requests_sent == replies_seen) quiet_cycles = quiet_cycles + 1;
      else quiet_cycles = 0;

      if (!start_next) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
        end else if (pending_q.size() > 0) begin
          head = pending_q[0];
          case (head.kind)
            ENTRY_REQUEST: begin
              void'(pending_q.pop_front());
              in_flight     = head.req;
              operation_i   <= head.req.operation;
              character_i   <= head.req.glyph;
              read_row_i    <= head.req.row;
              read_column_i <= head.req.column;
              start_next    = 1'b1;
              gap_left      = head.gap;
            end
            ENTRY_CONFIG: begin
              if (quiet_cycles >= SETTLE_CYCLES) begin
                void'(pending_q.pop_front());
                text_attribute_i <= head.attr;
                we_next      = 1'b1;
                attr_model   = head.attr;
                quiet_cycles = 0;
              end
            end
            default: begin
              if (quiet_cycles >= SETTLE_CYCLES) begin
                void'(pending_q.pop_front());
                quiet_cycles = 0;
              end
            end
          endcase
        end
      end
      start               <= start_next;
      text_attribute_we_i <= we_next;
    end
  end

  // Monitor: every done strobe is checked against the oldest predicted reply.
  always @(posedge clk_i) begin
    console_reply_t want;
    if (rst_ni && done_o) begin
      replies_seen <= replies_seen + 1;
      if (console_replies_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = console_replies_q.pop_front();
        if (cell_word_o !== want.cell_word)
          report_mismatch($sformatf("cell_word got %h want %h", cell_word_o, want.cell_word));
        if (cursor_row_o !== want.cursor_row)
          report_mismatch($sformatf("cursor_row got %0d want %0d",
                                    cursor_row_o, want.cursor_row));
        if (cursor_column_o !== want.cursor_column)
          report_mismatch($sformatf("cursor_column got %0d want %0d",
                                    cursor_column_o, want.cursor_column));
        if (scrolled_o !== want.scrolled)
          report_mismatch($sformatf("scrolled got %b want %b", scrolled_o, want.scrolled));
      end
    end
  end

  // Run limit, sized from the stimulus before the first clock edge.
  initial begin
    @(posedge clk_i);
    while (cycle_count < cycle_limit) @(posedge clk_i);
    $display("simulation failed");
    $finish;
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned                phase;
    longint unsigned            phase_end;
    int unsigned                pick;
    int unsigned                n;
    logic                       full_range;
    logic [tcw_pkg::ATTR_W-1:0] phase_attr;

    for (int i = 0; i < SCREEN_CELLS; i++) screen_model[i] = tcw_pkg::BLANK_CELL;

    // Directed: glyph extremes, both operations, reads at two opposite corners and off the screen.
    queue_read(0, 0);
    queue_request(tcw_pkg::OP_PUT, 8'h00, '1, '1);
    queue_request(tcw_pkg::OP_PUT, 8'hFF, '0, '0);
    queue_put("A");
    queue_read(0, 0);
    queue_read(0, 1);
    queue_put(tcw_pkg::NEWLINE_GLYPH);
    queue_read(ROWS - 1, COLUMNS - 1);
    queue_read(ROWS, 0);
    queue_read(0, COLUMNS);
    queue_request(tcw_pkg::OP_READ, 8'hFF, '1, '1);
    queue_request(tcw_pkg::OP_READ, 8'h00, '0, '0);
    queue_read(0, 2);

    // Walk down to the bottom row and two newlines further so the screen scrolls twice.
    for (int i = 0; i < ROWS; i++) queue_put(tcw_pkg::NEWLINE_GLYPH);
    queue_read(0, 0);
    queue_read(ROWS - 1, 0);

    // Random phases, each under a chosen attribute; the last one runs without idling.
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: phase_attr = tcw_pkg::RESET_ATTR;
        1: phase_attr = 8'hFF;
        2: phase_attr = 8'h00;
        3: phase_attr = tcw_pkg::ATTR_W'($urandom);
        default: phase_attr = tcw_pkg::RESET_ATTR;
      endcase
      if (phase != 0) queue_hold(ENTRY_CONFIG, phase_attr);
      phase_end = request_total + PHASE_ITEMS;
      while (request_total < phase_end) begin
        idle_on = (phase != PHASE_COUNT - 1) && ($urandom_range(0, 9) < 7);
        pick = $urandom_range(0, 9);
        if (pick <= 3) begin
          // Line of text, usually closed by a newline.
          n = $urandom_range(1, 90);
          full_range = ($urandom_range(0, 3) == 0);
          for (int i = 0; i < n; i++) begin
            queue_put(full_range ? tcw_pkg::GLYPH_W'($urandom) :
                                   tcw_pkg::GLYPH_W'($urandom_range(32, 126)));
          end
          if ($urandom_range(0, 9) < 7) queue_put(tcw_pkg::NEWLINE_GLYPH);
        end else if (pick == 4) begin
          // Line long enough to wrap.
          n = $urandom_range(COLUMNS, 2 * COLUMNS + 10);
          for (int i = 0; i < n; i++) queue_put(tcw_pkg::GLYPH_W'($urandom_range(32, 126)));
        end else if (pick == 5) begin
          n = $urandom_range(1, 12);
          for (int i = 0; i < n; i++) queue_put(tcw_pkg::NEWLINE_GLYPH);
        end else if (pick <= 7) begin
          n = $urandom_range(1, 12);
          for (int i = 0; i < n; i++) begin
            queue_read($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1));
          end
        end else if (pick == 8) begin
          // Reads over the whole field range, mostly off the screen.
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) begin
            queue_read($urandom_range(0, 31), $urandom_range(0, 127));
          end
        end else begin
          n = $urandom_range(1, 10);
          for (int i = 0; i < n; i++) begin
            queue_request(1'($urandom), tcw_pkg::GLYPH_W'($urandom),
                          tcw_pkg::ROW_W'($urandom), tcw_pkg::COL_W'($urandom));
          end
        end
        // In the middle of the second phase, hold the sender until every result is back.
        if (phase == 1 && request_total >= phase_end - PHASE_ITEMS / 2 &&
            request_total < phase_end - PHASE_ITEMS / 2 + 40) begin
          queue_hold(ENTRY_DRAIN, '0);
        end
      end
    end

    cycle_limit = 4 * (request_total * 16 +
                       (newline_total + put_total / COLUMNS + 2) * (SCREEN_CELLS + 4) +
                       SCREEN_CELLS + config_total * 16 + 100);

    // Reset once, then let the driver work through the queue.
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || start || requests_sent != replies_seen) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (console_replies_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", console_replies_q.size()));
    end

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
src/tcw_pkg.sv
src/tcw_screen_ram.sv
src/text_console_writer_unit.sv
bench/text_console_writer_unit_tb.sv
